// ----- rtl/gtp_pkg.sv -----
// shared types, constants and tables of the go-to-point controller
package gtp_pkg;

    localparam int CordicIterDefault = 16;
    localparam int PosFracDefault    = 16;
    localparam int AngFracDefault    = 13;

    localparam int AtanFrac   = 30;
    localparam int GuardShift = 8;
    // cordic datapath width: 33-bit difference, guard bits, growth and sign
    localparam int CW = 44;
    localparam int ZW = 34;

    localparam logic signed [ZW-1:0] PiQ30 = 34'sd3373259426;
    localparam logic [16:0] InvGainQ16 = 17'd39797;
    localparam logic [32:0] RangeMax = 33'h1_FFFF_FFFF;

    // command codes
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    // status codes
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_VALID    = 3'd1;
    localparam logic [2:0] ST_NO_POSE  = 3'd2;
    localparam logic [2:0] ST_SUCCESS  = 3'd3;
    localparam logic [2:0] ST_CANCELED = 3'd4;

    // navigation phases
    localparam logic [1:0] PH_ALIGN = 2'd0;
    localparam logic [1:0] PH_DRIVE = 2'd1;
    localparam logic [1:0] PH_FINAL = 2'd2;

    // register indexes
    localparam logic [1:0] REG_GOAL_X   = 2'd0;
    localparam logic [1:0] REG_GOAL_Y   = 2'd1;
    localparam logic [1:0] REG_GOAL_HDG = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_ITER,
        S_SCALE,
        S_POST,
        S_DECIDE,
        S_OUT
    } gtp_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic iter;
        logic scale;
        logic post;
        logic decide;
    } gtp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic iter_done;
    } gtp_stat_t;

    // arctangent table, 30 fraction bits
    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        begin
            unique case (i)
                5'd0:  v = 34'sd843314857;
                5'd1:  v = 34'sd497837829;
                5'd2:  v = 34'sd263043837;
                5'd3:  v = 34'sd133525159;
                5'd4:  v = 34'sd67021687;
                5'd5:  v = 34'sd33543516;
                5'd6:  v = 34'sd16775851;
                5'd7:  v = 34'sd8388437;
                5'd8:  v = 34'sd4194283;
                5'd9:  v = 34'sd2097149;
                5'd10: v = 34'sd1048576;
                5'd11: v = 34'sd524288;
                5'd12: v = 34'sd262144;
                5'd13: v = 34'sd131072;
                5'd14: v = 34'sd65536;
                5'd15: v = 34'sd32768;
                5'd16: v = 34'sd16384;
                5'd17: v = 34'sd8192;
                5'd18: v = 34'sd4096;
                5'd19: v = 34'sd2048;
                5'd20: v = 34'sd1024;
                5'd21: v = 34'sd512;
                5'd22: v = 34'sd256;
                5'd23: v = 34'sd128;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- rtl/go_to_point_pose_controller_unit.sv -----
// go-to-point controller top level
//  channel | dir | tuser            | tdata
//  s_axis  | in  | cmd, pose_valid  | robot_x, robot_y, robot_yaw
//  m_axis  | out | status, phase    | linear_speed, turn_rate, range_to_goal
//  cfg     | in  | -                | index 0 goal_x, 1 goal_y, 2 goal_heading
// after an item is taken the sequencer steps through prep, the cordic iterations, scale,
// post and decide before the result is valid; the next item is taken after it is accepted
// the shared cordic micro-rotation stage does one rotation per cycle
// one item at a time; a stalled result waits in registers and holds off the input
// rst_n clears the goal registers, goal state and sequencer asynchronously
module go_to_point_pose_controller_unit
#(
    parameter int CORDIC_ITERATIONS = gtp_pkg::CordicIterDefault,
    parameter int POS_FRAC_BITS     = gtp_pkg::PosFracDefault,
    parameter int ANGLE_FRAC_BITS   = gtp_pkg::AngFracDefault
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[1:0], pose_valid[2]
    input  logic [2:0]   s_axis_tuser,
    // robot_x[31:0], robot_y[63:32], robot_yaw[79:64]
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], phase[4:3]
    output logic [4:0]   m_axis_tuser,
    // linear_speed[13:0], turn_rate[29:14], range_to_goal[62:30]
    output logic [63:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import gtp_pkg::*;

    gtp_cmd_t   cmd;
    gtp_stat_t  stat;
    logic        in_fire, out_fire;
    logic [13:0] lin;
    logic [15:0] turn;
    logic [32:0] rng;
    logic [2:0]  st;
    logic [1:0]  ph;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    gtp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid)
    );

    gtp_dp #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .POS_FRAC_BITS     (POS_FRAC_BITS),
        .ANGLE_FRAC_BITS   (ANGLE_FRAC_BITS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_cmd        (s_axis_tuser[1:0]),
        .in_pose_valid (s_axis_tuser[2]),
        .in_x          (s_axis_tdata[31:0]),
        .in_y          (s_axis_tdata[63:32]),
        .in_yaw        (s_axis_tdata[79:64]),
        .linear_speed  (lin),
        .turn_rate     (turn),
        .range_to_goal (rng),
        .status        (st),
        .phase         (ph)
    );

    assign m_axis_tdata = {1'b0, rng, turn, lin};
    assign m_axis_tuser = {ph, st};

endmodule

// ----- rtl/gtp_ctrl.sv -----
// sequencer of the go-to-point controller
module gtp_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic               out_fire,
    input  gtp_pkg::gtp_stat_t stat,
    output gtp_pkg::gtp_cmd_t  cmd,
    output logic               in_ready,
    output logic               out_valid
);
    import gtp_pkg::*;

    gtp_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                cmd.iter = 1'b1;
                if (stat.iter_done)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_POST;
            end
            S_POST:
            begin
                cmd.post   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // handshakes exclusive, an accepted item starts, a decision presents a result
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("ready and valid together");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_PREP)
        else $error("accepted item did not start");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |=> out_valid)
        else $error("result not presented");

endmodule

// ----- rtl/gtp_dp.sv -----
// cordic and control-law datapath of the go-to-point controller
module gtp_dp
#(
    parameter int CORDIC_ITERATIONS = gtp_pkg::CordicIterDefault,
    parameter int POS_FRAC_BITS     = gtp_pkg::PosFracDefault,
    parameter int ANGLE_FRAC_BITS   = gtp_pkg::AngFracDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  gtp_pkg::gtp_cmd_t  cmd,
    output gtp_pkg::gtp_stat_t stat,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic [1:0]         in_cmd,
    input  logic               in_pose_valid,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [15:0] in_yaw,
    output logic [13:0]        linear_speed,
    output logic signed [15:0] turn_rate,
    output logic [32:0]        range_to_goal,
    output logic [2:0]         status,
    output logic [1:0]         phase
);
    import gtp_pkg::*;

    localparam int NIT = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
    localparam int RS  = AtanFrac - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] ZRound = ZW'(64'sd1 <<< (RS - 1));
    localparam longint PiA = (64'sd3373259426 + (64'sd1 <<< (RS - 1))) >>> RS;
    localparam longint HeadTol  = ((64'sd1 <<< ANGLE_FRAC_BITS) + 5) / 10;
    localparam longint FinalTol = ((64'sd1 <<< ANGLE_FRAC_BITS) + 10) / 20;
    localparam longint DistTol  = ((64'sd1 <<< POS_FRAC_BITS) + 5) / 10;
    localparam longint OneM     = 64'sd1 <<< POS_FRAC_BITS;
    localparam int TurnSh = 13 - ANGLE_FRAC_BITS;
    localparam int TurnSh1 = 14 - ANGLE_FRAC_BITS;

    // goal registers
    logic signed [31:0] goal_x_reg, goal_y_reg;
    logic signed [15:0] goal_hdg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg   <= '0;
            goal_y_reg   <= '0;
            goal_hdg_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_GOAL_X)
            begin
                goal_x_reg <= cfg_data;
            end
            if (cfg_index == REG_GOAL_Y)
            begin
                goal_y_reg <= cfg_data;
            end
            if (cfg_index == REG_GOAL_HDG)
            begin
                goal_hdg_reg <= cfg_data[15:0];
            end
        end
    end

    // captured item
    logic [1:0]         cmd_reg;
    logic               pv_reg;
    logic signed [31:0] rx_reg, ry_reg;
    logic signed [15:0] yaw_reg;
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [4:0]           it_reg;
    logic                 zero_reg;
    logic [32:0]          range_reg;
    logic signed [17:0]   herr_reg, ferr_reg;
    logic signed [ZW-1:0] bear_w;
    logic signed [CW-1:0] xs, ys;
    logic signed [32:0]   dx, dy;
    logic [CW+16:0]       prod;
    logic [CW+16:0]       rr;
    logic signed [17:0]   bear, hraw, fraw, herr_n, ferr_n;

    // goal state
    logic       active_reg;
    logic [1:0] nph_reg;

    assign dx = 33'(goal_x_reg) - 33'(rx_reg);
    assign dy = 33'(goal_y_reg) - 33'(ry_reg);
    assign xs = x_reg >>> it_reg;
    assign ys = y_reg >>> it_reg;
    assign stat.iter_done = (it_reg == 5'(NIT - 1));

    // item capture, cordic vectoring with one micro-rotation per cycle, range and error registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= in_cmd;
            pv_reg  <= in_pose_valid;
            rx_reg  <= in_x;
            ry_reg  <= in_y;
            yaw_reg <= in_yaw;
        end
        if (cmd.prep)
        begin
            it_reg   <= '0;
            zero_reg <= (dx == 0) && (dy == 0);
            if (dx < 0)
            begin
                x_reg <= -(CW'(dx) <<< GuardShift);
                y_reg <= -(CW'(dy) <<< GuardShift);
                z_reg <= (dy >= 0) ? PiQ30 : -PiQ30;
            end
            else
            begin
                x_reg <= CW'(dx) <<< GuardShift;
                y_reg <= CW'(dy) <<< GuardShift;
                z_reg <= '0;
            end
        end
        if (cmd.iter)
        begin
            it_reg <= it_reg + 5'd1;
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_q30(it_reg);
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_q30(it_reg);
            end
        end
        if (cmd.scale)
        begin
            range_reg <= (rr > (CW+17)'(RangeMax)) ? RangeMax : rr[32:0];
        end
        if (cmd.post)
        begin
            herr_reg <= herr_n;
            ferr_reg <= ferr_n;
        end
    end

    // range scaling by the inverse cordic gain
    assign prod = (CW+17)'(x_reg) * (CW+17)'(InvGainQ16);
    assign rr   = (prod + (CW+17)'(64'd1 << (15 + GuardShift))) >> (16 + GuardShift);

    // bearing rounding and angle wrap (one correction reaches the range)
    assign bear_w = (z_reg + ZRound) >>> RS;
    assign bear   = zero_reg ? 18'sd0 : 18'(bear_w);
    assign hraw   = bear - 18'(yaw_reg);
    assign fraw   = 18'(goal_hdg_reg) - 18'(yaw_reg);

    function automatic logic signed [17:0] wrap(input logic signed [17:0] a);
        logic signed [17:0] v;
        begin
            v = a;
            if (v > 18'(PiA))
            begin
                v = v - 18'(2 * PiA);
            end
            if (v > 18'(PiA))
            begin
                v = v - 18'(2 * PiA);
            end
            if (v < -18'(PiA))
            begin
                v = v + 18'(2 * PiA);
            end
            if (v < -18'(PiA))
            begin
                v = v + 18'(2 * PiA);
            end
            return v;
        end
    endfunction

    assign herr_n = wrap(hraw);
    assign ferr_n = wrap(fraw);

    function automatic logic signed [15:0] clampv(input logic signed [21:0] v,
                                                  input logic signed [21:0] lim);
        begin
            if (v > lim)
            begin
                return 16'(lim);
            end
            else if (v < -lim)
            begin
                return 16'(-lim);
            end
            return 16'(v);
        end
    endfunction

    // control law and goal bookkeeping
    logic signed [21:0] t3h, t3f, t1;
    assign t3h = (22'(herr_reg) * 22'sd3) <<< TurnSh;
    assign t3f = (22'(ferr_reg) * 22'sd3) <<< TurnSh;
    assign t1  = 22'(herr_reg) <<< TurnSh1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            nph_reg       <= PH_ALIGN;
            linear_speed  <= '0;
            turn_rate     <= '0;
            range_to_goal <= '0;
            status        <= ST_IDLE;
            phase         <= PH_ALIGN;
        end
        else if (cmd.decide)
        begin
            linear_speed  <= '0;
            turn_rate     <= '0;
            range_to_goal <= '0;
            status        <= ST_IDLE;
            phase         <= nph_reg;
            if (cmd_reg == CMD_START)
            begin
                active_reg <= 1'b1;
                nph_reg    <= PH_ALIGN;
                phase      <= PH_ALIGN;
                status     <= ST_VALID;
            end
            else if (cmd_reg == CMD_CANCEL)
            begin
                if (active_reg)
                begin
                    active_reg <= 1'b0;
                    nph_reg    <= PH_ALIGN;
                    status     <= ST_CANCELED;
                end
            end
            else if (active_reg)
            begin
                if (!pv_reg)
                begin
                    status <= ST_NO_POSE;
                end
                else
                begin
                    range_to_goal <= range_reg;
                    status        <= ST_VALID;
                    if (nph_reg == PH_ALIGN)
                    begin
                        if (herr_reg > 18'(HeadTol) || herr_reg < -18'(HeadTol))
                        begin
                            turn_rate <= clampv(t3h, 22'sd16384);
                        end
                        else
                        begin
                            nph_reg <= PH_DRIVE;
                        end
                    end
                    else if (nph_reg == PH_DRIVE)
                    begin
                        if (range_reg > 33'(DistTol))
                        begin
                            linear_speed <= (range_reg >= 33'(OneM)) ? 14'd8192
                                : 14'((46'(range_reg) << 13) >> POS_FRAC_BITS);
                            turn_rate <= clampv(t1, 22'sd8192);
                        end
                        else
                        begin
                            nph_reg <= PH_FINAL;
                        end
                    end
                    else
                    begin
                        if (ferr_reg > 18'(FinalTol) || ferr_reg < -18'(FinalTol))
                        begin
                            turn_rate <= clampv(t3f, 22'sd16384);
                        end
                        else
                        begin
                            status     <= ST_SUCCESS;
                            active_reg <= 1'b0;
                            nph_reg    <= PH_ALIGN;
                        end
                    end
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) nph_reg != 2'd3)
        else $error("bad phase");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decide && cmd_reg == CMD_START) |=> active_reg && status == ST_VALID)
        else $error("start did not arm goal");
    assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> nph_reg == PH_ALIGN)
        else $error("phase left while idle");

endmodule

// ----- tb/tb_top.sv -----
// testbench for the go-to-point controller: directed table, then random pose runs
`timescale 1ns / 1ps

module tb_top;
    import gtp_pkg::*;

    localparam int        LIMIT_CYCLES = 1_000_000;
    localparam int        RAND_ITEMS   = 2000;
    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam longint    PI_STEPS     = 25736;
    localparam longint    HEAD_TOL     = 819;
    localparam longint    FINAL_TOL    = 410;
    localparam longint    DIST_TOL     = 6554;
    localparam longint    ONE_METER    = 65536;

    typedef struct {
        logic [1:0]         cmd;
        logic               pose_valid;
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic signed [15:0] robot_yaw;
    } pose_item_t;

    typedef struct packed {
        logic [13:0]        linear_speed;
        logic signed [15:0] turn_rate;
        logic [32:0]        range_to_goal;
        logic [2:0]         status;
        logic [1:0]         phase;
    } drive_cmd_t;

    typedef struct {
        pose_item_t item;
        bit         known;
        drive_cmd_t want;
    } dir_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [2:0]   s_axis_tuser = '0;
    logic [79:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [4:0]   m_axis_tuser;
    logic [63:0]  m_axis_tdata;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = REG_GOAL_X;
    logic [31:0]  cfg_data = '0;

    // controller copy kept by the testbench
    longint     tgt_x, tgt_y, tgt_hdg;
    bit         goal_armed;
    logic [1:0] cur_phase;

    drive_cmd_t pending_cmds[$];
    int         mismatches;
    int         cycles;
    int         tx_idle_pct;
    int         rx_stall_pct;

    go_to_point_pose_controller_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // range and bearing of a difference vector by cordic vectoring
    task automatic polar(input longint dx, input longint dy,
                         output longint rng, output longint bearing);
        longint x, y, z, xs, ys, r;
        longint atan_q30[16] = '{843314857, 497837829, 263043837, 133525159,
            67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
            524288, 262144, 131072, 65536, 32768};
        x = dx * 256;
        y = dy * 256;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys;
                y -= xs;
                z += atan_q30[i];
            end
            else
            begin
                x -= ys;
                y += xs;
                z -= atan_q30[i];
            end
        end
        r = (x * 39797 + (64'sd1 << 23)) >>> 24;
        rng = (r > 64'sd8589934591) ? 64'sd8589934591 : r;
        if (dx == 0 && dy == 0)
            z = 0;
        bearing = (z + (64'sd1 << 16)) >>> 17;
    endtask

    function automatic longint fold_pi(input longint a);
        longint v;
        v = a;
        while (v > PI_STEPS) v -= 2 * PI_STEPS;
        while (v < -PI_STEPS) v += 2 * PI_STEPS;
        return v;
    endfunction

    function automatic longint clip(input longint v, input longint lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    // next drive command for one accepted item, advances the goal state
    task automatic steer(input pose_item_t it, output drive_cmd_t res);
        longint rng, brg, herr, ferr, turn, lin;
        rng = 0;
        turn = 0;
        lin = 0;
        res = '0;
        res.phase = cur_phase;
        if (it.cmd == CMD_START)
        begin
            goal_armed = 1;
            cur_phase = PH_ALIGN;
            res.phase = PH_ALIGN;
            res.status = ST_VALID;
        end
        else if (it.cmd == CMD_CANCEL)
        begin
            if (goal_armed)
            begin
                goal_armed = 0;
                cur_phase = PH_ALIGN;
                res.status = ST_CANCELED;
            end
        end
        else if (goal_armed)
        begin
            if (!it.pose_valid)
                res.status = ST_NO_POSE;
            else
            begin
                polar(tgt_x - it.robot_x, tgt_y - it.robot_y, rng, brg);
                herr = fold_pi(brg - it.robot_yaw);
                ferr = fold_pi(tgt_hdg - it.robot_yaw);
                res.status = ST_VALID;
                if (res.phase == PH_ALIGN)
                begin
                    if (herr > HEAD_TOL || herr < -HEAD_TOL)
                        turn = clip(herr * 3, 16384);
                    else
                        cur_phase = PH_DRIVE;
                end
                else if (res.phase == PH_DRIVE)
                begin
                    if (rng > DIST_TOL)
                    begin
                        lin = (rng >= ONE_METER) ? 8192 : ((rng * 8192) >>> 16);
                        turn = clip(herr * 2, 8192);
                    end
                    else
                        cur_phase = PH_FINAL;
                end
                else
                begin
                    if (ferr > FINAL_TOL || ferr < -FINAL_TOL)
                        turn = clip(ferr * 3, 16384);
                    else
                    begin
                        res.status = ST_SUCCESS;
                        goal_armed = 0;
                        cur_phase = PH_ALIGN;
                    end
                end
            end
        end
        res.linear_speed = lin[13:0];
        res.turn_rate = turn[15:0];
        res.range_to_goal = rng[32:0];
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_GOAL_X)
            tgt_x = longint'(signed'(val));
        else if (idx == REG_GOAL_Y)
            tgt_y = longint'(signed'(val));
        else
            tgt_hdg = longint'(signed'(val[15:0]));
    endtask

    task automatic set_goal(input logic [31:0] gx, input logic [31:0] gy,
                            input logic [15:0] gh);
        write_reg(REG_GOAL_X, gx);
        write_reg(REG_GOAL_Y, gy);
        write_reg(REG_GOAL_HDG, {16'd0, gh});
    endtask

    // wait for every result, then let the block settle before a register write
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    // offer one item, sometimes after a random gap; called at a falling edge
    task automatic send_pose(input pose_item_t it, input bit known,
                             input drive_cmd_t want);
        drive_cmd_t res;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {it.pose_valid, it.cmd};
        s_axis_tdata <= {it.robot_yaw, it.robot_y, it.robot_x};
        do @(posedge clk); while (!s_axis_tready);
        steer(it, res);
        pending_cmds.push_back(known ? want : res);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] near32(input longint base, input longint off);
        longint v;
        v = base + off;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // random item, mostly well-formed goal runs that walk the phases
    task automatic pick_pose(output pose_item_t it);
        int     r, p;
        longint rng, brg, yaw, span;
        it.cmd = CMD_TICK;
        it.pose_valid = 1'b1;
        r = $urandom_range(0, 99);
        if (!goal_armed && r < 60)
            it.cmd = CMD_START;
        else if (r < 2)
            it.cmd = CMD_START;
        else if (r < 5)
            it.cmd = CMD_CANCEL;
        else if (r < 7)
            it.cmd = CMD_SPARE;
        else if (r < 11)
            it.pose_valid = 1'b0;
        p = $urandom_range(0, 9);
        span = (p < 6) ? 1048576 : 5000;
        if (p < 2)
        begin
            it.robot_x = $urandom;
            it.robot_y = $urandom;
        end
        else
        begin
            it.robot_x = near32(tgt_x, longint'($urandom_range(0, 2 * span)) - span);
            it.robot_y = near32(tgt_y, longint'($urandom_range(0, 2 * span)) - span);
        end
        polar(tgt_x - it.robot_x, tgt_y - it.robot_y, rng, brg);
        r = $urandom_range(0, 9);
        if (r < 2)
            yaw = longint'($urandom_range(0, 2 * PI_STEPS)) - PI_STEPS;
        else if (cur_phase == PH_FINAL || r < 4)
            yaw = tgt_hdg + longint'($urandom_range(0, 1200)) - 600;
        else
            yaw = brg + longint'($urandom_range(0, 2000)) - 1000;
        it.robot_yaw = 16'(clip(yaw, PI_STEPS));
    endtask

    // result checker
    always @(posedge clk)
    begin
        drive_cmd_t got, want;
        cycles <= cycles + 1;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.linear_speed = m_axis_tdata[13:0];
            got.turn_rate = m_axis_tdata[29:14];
            got.range_to_goal = m_axis_tdata[62:30];
            got.status = m_axis_tuser[2:0];
            got.phase = m_axis_tuser[4:3];
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: speed %0d turn %0d range %0d status %0d phase %0d",
                             got.linear_speed, got.turn_rate, got.range_to_goal,
                             got.status, got.phase);
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp speed %0d turn %0d range %0d status %0d phase %0d, got speed %0d turn %0d range %0d status %0d phase %0d",
                                 want.linear_speed, want.turn_rate, want.range_to_goal,
                                 want.status, want.phase, got.linear_speed,
                                 got.turn_rate, got.range_to_goal, got.status, got.phase);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (cycles > LIMIT_CYCLES)
        begin
            $display("[go_to_point_pose_controller_unit] ERROR");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    initial
    begin
        dir_row_t   dir_tab[$];
        pose_item_t it;
        drive_cmd_t none;
        drive_cmd_t z;
        cycles = 0;
        mismatches = 0;
        tx_idle_pct = 26;
        rx_stall_pct = 78;
        tgt_x = 0;
        tgt_y = 0;
        tgt_hdg = 0;
        goal_armed = 0;
        cur_phase = PH_ALIGN;
        none = '0;

        z = '0;
        // idle tick, idle cancel, start, no pose, cancel while running
        dir_tab.push_back('{'{CMD_TICK, 1'b1, 32'sd100, -32'sd100, 16'sd5}, 1, z});
        dir_tab.push_back('{'{CMD_CANCEL, 1'b0, 32'sd0, 32'sd0, 16'sd0}, 1, z});
        z.status = ST_VALID;
        dir_tab.push_back('{'{CMD_START, 1'b1, 32'sd7, 32'sd7, 16'sd0}, 1, z});
        z.status = ST_NO_POSE;
        dir_tab.push_back('{'{CMD_TICK, 1'b0, -32'sd1, -32'sd1, -16'sd1}, 1, z});
        z.status = ST_CANCELED;
        dir_tab.push_back('{'{CMD_CANCEL, 1'b1, 32'sd0, 32'sd0, 16'sd0}, 1, z});
        // extremes of position and yaw, mostly far from the goal
        dir_tab.push_back('{'{CMD_START, 1'b1, 32'sd0, 32'sd0, 16'sd0}, 0, none});
        dir_tab.push_back('{'{CMD_TICK, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 16'sd25736}, 0, none});
        dir_tab.push_back('{'{CMD_TICK, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, -16'sd25736}, 0, none});
        dir_tab.push_back('{'{CMD_SPARE, 1'b1, 32'h8000_0000, 32'h8000_0000, 16'sd0}, 0, none});
        dir_tab.push_back('{'{CMD_TICK, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 16'sd12000}, 0, none});
        // robot on the goal: align, reach, then turn to the heading and succeed
        dir_tab.push_back('{'{CMD_TICK, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 16'sd0}, 0, none});
        dir_tab.push_back('{'{CMD_TICK, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 16'sd0}, 0, none});
        dir_tab.push_back('{'{CMD_TICK, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 16'sd0}, 0, none});
        dir_tab.push_back('{'{CMD_TICK, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, -16'sd20000}, 0, none});
        dir_tab.push_back('{'{CMD_TICK, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 16'sd25736}, 0, none});
        dir_tab.push_back('{'{CMD_TICK, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 16'sd25736}, 0, none});
        // restart while running
        dir_tab.push_back('{'{CMD_START, 1'b1, 32'sd0, 32'sd0, 16'sd0}, 0, none});
        dir_tab.push_back('{'{CMD_START, 1'b0, 32'sd0, 32'sd0, 16'sd0}, 0, none});
        dir_tab.push_back('{'{CMD_TICK, 1'b1, 32'h7FFF_0000, 32'h8000_FFFF, 16'sd300}, 0, none});

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part against the corner goal at maximum x and minimum y
        set_goal(32'h7FFF_FFFF, 32'h8000_0000, 16'sd25736);
        foreach (dir_tab[i])
            send_pose(dir_tab[i].item, dir_tab[i].known, dir_tab[i].want);
        drain();

        // random runs, three pacing modes, new goal for each
        for (int m = 0; m < 3; m++)
        begin
            if (m == 0)
                set_goal(32'h8000_0000, 32'h7FFF_FFFF, -16'sd25736);
            else if (m == 1)
                set_goal($urandom, $urandom, $urandom_range(0, 51472) - 25736);
            else
            begin
                set_goal($urandom_range(0, 1 << 20), -$urandom_range(0, 1 << 20), 16'sd0);
                tx_idle_pct = 0;
                rx_stall_pct = 0;
            end
            if (m == 1)
            begin
                tx_idle_pct = 78;
                rx_stall_pct = 26;
            end
            for (int n = 0; n < RAND_ITEMS / 3; n++)
            begin
                pick_pose(it);
                send_pose(it, 0, none);
            end
            drain();
        end

        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("[go_to_point_pose_controller_unit] OK");
        else
            $display("[go_to_point_pose_controller_unit] ERROR");
        $finish;
    end

endmodule
